// ===== design/cross_stencil_blur_stream_unit_defines.svh =====
// Assertion macros for the cross stencil blur stream unit.
// Used by the port checker; no other dependencies.
`ifndef CROSS_STENCIL_BLUR_STREAM_UNIT_DEFINES_SVH
`define CROSS_STENCIL_BLUR_STREAM_UNIT_DEFINES_SVH

// clocked assertion, ignored while reset is high
`define CSBS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define CSBS_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/csbs_pkg.sv =====
// Shared constants and types for the cross stencil blur stream unit.
// No dependencies.
`default_nettype none

package csbs_pkg;

   localparam int MAX_SIDE   = 128;
   localparam int COL_W      = $clog2(MAX_SIDE);
   localparam int CHAN_W     = 16;
   localparam int SUM_W      = CHAN_W + 3;
   localparam int SIDE_W     = 8;
   localparam int SIDE_MIN   = 3;
   localparam int SIDE_RESET = 65;
   localparam int FIFTH_MUL  = 13107;
   localparam int ROUND_HALF = 32768;
   localparam int OUT_POS_W  = 7;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_GRID_SIDE = 1'b0;

   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = FIFO_PTR_W + 2;

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } pixel_type;

   // one column of the line store: the two most recent rows
   typedef struct packed {
      pixel_type older;
      pixel_type newer;
   } store_entry_type;

   typedef struct packed {
      logic            en;
      logic [COL_W-1:0] addr;
      store_entry_type data;
   } store_wr_type;

   typedef struct packed {
      logic                 run_end;
      logic [CHAN_W-1:0]    blue;
      logic [CHAN_W-1:0]    green;
      logic [CHAN_W-1:0]    red;
      logic [OUT_POS_W-1:0] col;
      logic [OUT_POS_W-1:0] row;
   } result_type;

endpackage

`default_nettype wire

// ===== design/csbs_line_store.sv =====
// Line store of the blur unit: one column entry per address, two rows wide.
// Synchronous RAM, one read and one write port, registered read data. Uses csbs_pkg.
`default_nettype none

module csbs_line_store (
   input  wire logic                        clock,
   input  wire logic                        rd_en,
   input  wire logic [csbs_pkg::COL_W-1:0]  rd_addr,
   output csbs_pkg::store_entry_type        rd_data,
   input  csbs_pkg::store_wr_type           wr
);

   csbs_pkg::store_entry_type mem [csbs_pkg::MAX_SIDE];
   csbs_pkg::store_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/cross_stencil_blur_stream_unit.sv =====
// Top level of the five-point cross blur over a raster RGB stream.
// Uses csbs_pkg and csbs_line_store.
//
//  port group | dir | payload (low bit first)
//  req_*      | in  | tdata: red, green, blue (16 b each)
//  rsp_*      | out | tdata: row(7), col(7), red, green, blue; tlast: run_end
//  csr_*      | in  | grid_side at byte address 0
//
// One pixel per cycle while req_tready is high; each result passes stage 1, stage 2
// and the result queue. Inputs on the last row give two results, so there the output
// port sets the pace. Each pixel does one line-store read and one write.
// Reset clears counters and control; the line store is not cleared.
// req_tready drops when the 8-entry result queue cannot take the worst case in flight.
`default_nettype none

module cross_stencil_blur_stream_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   input  wire logic [47:0]                         req_tdata,  // red, green, blue
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   output      logic [63:0]                         rsp_tdata,  // row, col, red, green, blue
   output      logic                                rsp_tlast,  // run_end
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [csbs_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [csbs_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output      logic [csbs_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output      logic                                csr_pready
);

   localparam int COL_W = csbs_pkg::COL_W;
   localparam int SUM_W = csbs_pkg::SUM_W;

   function automatic logic [SUM_W-1:0] sum5(input logic [csbs_pkg::CHAN_W-1:0] a,
                                             input logic [csbs_pkg::CHAN_W-1:0] b,
                                             input logic [csbs_pkg::CHAN_W-1:0] c,
                                             input logic [csbs_pkg::CHAN_W-1:0] d,
                                             input logic [csbs_pkg::CHAN_W-1:0] e);
      return SUM_W'(a) + SUM_W'(b) + SUM_W'(c) + SUM_W'(d) + SUM_W'(e);
   endfunction

   // round(s * 13107 / 65536), half up
   function automatic logic [csbs_pkg::CHAN_W-1:0] fifth(input logic [SUM_W-1:0] s);
      logic [SUM_W+14-1:0] p;
      p = (SUM_W+14)'(s) * (SUM_W+14)'(csbs_pkg::FIFTH_MUL);
      p = p + (SUM_W+14)'(csbs_pkg::ROUND_HALF);
      return p[csbs_pkg::CHAN_W+15:16];
   endfunction

   // ---------------- configuration ----------------
   logic [csbs_pkg::SIDE_W-1:0] side_ff, side_in;
   logic                        csr_wr;
   logic [COL_W-1:0]            last_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready
                       & (csr_paddr[2] == csbs_pkg::REG_GRID_SIDE);
   assign csr_prdata = (csr_paddr[2] == csbs_pkg::REG_GRID_SIDE)
                       ? csbs_pkg::CSR_DATA_W'(side_ff) : '0;

   always_comb begin
      side_in = side_ff;
      if (csr_wr) begin
         side_in = csr_pwdata[csbs_pkg::SIDE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= csbs_pkg::SIDE_W'(csbs_pkg::SIDE_RESET);
      end else begin
         side_ff <= side_in;
      end
   end

   always_comb begin
      if (int'(side_ff) < csbs_pkg::SIDE_MIN) begin
         last_idx = COL_W'(csbs_pkg::SIDE_MIN - 1);
      end else if (int'(side_ff) > csbs_pkg::MAX_SIDE) begin
         last_idx = COL_W'(csbs_pkg::MAX_SIDE - 1);
      end else begin
         last_idx = COL_W'(int'(side_ff) - 1);
      end
   end

   // ---------------- position counters ----------------
   logic             accept;
   logic [COL_W-1:0] row_ff, row_in, col_ff, col_in;
   logic             col_last, row_last;
   logic [COL_W-1:0] rd_addr;

   assign accept   = req_tvalid & req_tready;
   assign col_last = (col_ff >= last_idx);
   assign row_last = (row_ff == last_idx);
   assign rd_addr  = col_last ? '0 : col_ff + COL_W'(1);

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (csr_wr) begin
         row_in = '0;
         col_in = '0;
      end else if (accept) begin
         if (col_last) begin
            col_in = '0;
            row_in = (row_ff >= last_idx) ? '0 : row_ff + COL_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // ---------------- stage 1: store read returns ----------------
   logic                      s1_valid_ff;
   logic [COL_W-1:0]          s1_row_ff, s1_col_ff;
   csbs_pkg::pixel_type       s1_cur_ff;
   logic                      s1_emit_ff, s1_lastrow_ff, s1_border_ff;
   csbs_pkg::store_entry_type rd_data, win_c_ff;
   csbs_pkg::pixel_type       win_p_ff;
   csbs_pkg::store_wr_type    st_wr;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_row_ff     <= row_ff;
         s1_col_ff     <= col_ff;
         s1_cur_ff     <= csbs_pkg::pixel_type'(req_tdata);
         s1_emit_ff    <= (row_ff != '0);
         s1_lastrow_ff <= row_last;
         s1_border_ff  <= (row_ff == COL_W'(1)) || (col_ff == '0) || col_last;
      end
   end

   csbs_line_store u_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr      (st_wr)
   );

   always_comb begin
      st_wr.en           = s1_valid_ff;
      st_wr.addr         = s1_col_ff;
      st_wr.data.older   = win_c_ff.newer;
      st_wr.data.newer   = s1_cur_ff;
   end

   // sliding window over the row above the current one
   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         win_p_ff <= win_c_ff.newer;
         win_c_ff <= rd_data;
      end
   end

   // ---------------- stage 2: sums ----------------
   logic             s2_valid_ff;
   logic [COL_W-1:0] s2_row_ff, s2_col_ff;
   logic             s2_emit_ff, s2_lastrow_ff, s2_border_ff;
   logic [SUM_W-1:0] s2_sum_r_ff, s2_sum_g_ff, s2_sum_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_row_ff     <= s1_row_ff;
         s2_col_ff     <= s1_col_ff;
         s2_emit_ff    <= s1_emit_ff;
         s2_lastrow_ff <= s1_lastrow_ff;
         s2_border_ff  <= s1_border_ff;
         s2_sum_r_ff   <= sum5(win_c_ff.older.red, win_c_ff.newer.red, win_p_ff.red,
                               rd_data.newer.red, s1_cur_ff.red);
         s2_sum_g_ff   <= sum5(win_c_ff.older.green, win_c_ff.newer.green, win_p_ff.green,
                               rd_data.newer.green, s1_cur_ff.green);
         s2_sum_b_ff   <= sum5(win_c_ff.older.blue, win_c_ff.newer.blue, win_p_ff.blue,
                               rd_data.newer.blue, s1_cur_ff.blue);
      end
   end

   // ---------------- result queue ----------------
   csbs_pkg::result_type               res0, res1;
   csbs_pkg::result_type               fifo_ff [csbs_pkg::FIFO_DEPTH];
   logic [csbs_pkg::FIFO_PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [csbs_pkg::FIFO_CNT_W-1:0]    count_ff, reserve;
   logic [1:0]                         wr_num;
   logic                               pop;
   csbs_pkg::result_type               head;

   always_comb begin
      res0.run_end = ~s2_lastrow_ff;
      res0.row     = csbs_pkg::OUT_POS_W'(s2_row_ff - COL_W'(1));
      res0.col     = csbs_pkg::OUT_POS_W'(s2_col_ff);
      res0.red     = s2_border_ff ? '0 : fifth(s2_sum_r_ff);
      res0.green   = s2_border_ff ? '0 : fifth(s2_sum_g_ff);
      res0.blue    = s2_border_ff ? '0 : fifth(s2_sum_b_ff);
      res1.run_end = 1'b1;
      res1.row     = csbs_pkg::OUT_POS_W'(s2_row_ff);
      res1.col     = csbs_pkg::OUT_POS_W'(s2_col_ff);
      res1.red     = '0;
      res1.green   = '0;
      res1.blue    = '0;
      wr_num       = 2'd0;
      if (s2_valid_ff && s2_emit_ff) begin
         wr_num = s2_lastrow_ff ? 2'd2 : 2'd1;
      end
   end

   assign pop     = rsp_tvalid & rsp_tready;
   assign reserve = count_ff + csbs_pkg::FIFO_CNT_W'({s1_valid_ff, 1'b0})
                    + csbs_pkg::FIFO_CNT_W'({s2_valid_ff, 1'b0});
   assign req_tready = (reserve <= csbs_pkg::FIFO_CNT_W'(csbs_pkg::FIFO_DEPTH - 2));

   always_ff @(posedge clock) begin
      if (wr_num != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= res0;
      end
      if (wr_num == 2'd2) begin
         fifo_ff[wr_ptr_ff + csbs_pkg::FIFO_PTR_W'(1)] <= res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + csbs_pkg::FIFO_PTR_W'(wr_num);
         rd_ptr_ff <= rd_ptr_ff + csbs_pkg::FIFO_PTR_W'(pop);
         count_ff  <= count_ff + csbs_pkg::FIFO_CNT_W'(wr_num)
                      - csbs_pkg::FIFO_CNT_W'(pop);
      end
   end

   assign head       = fifo_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tlast  = head.run_end;
   assign rsp_tdata  = {2'b00, head.blue, head.green, head.red, head.col, head.row};

endmodule

`default_nettype wire

// ===== design/csbs_checker.sv =====
// Port-level checker for the cross stencil blur stream unit, bound to the top level.
// Uses cross_stencil_blur_stream_unit_defines.svh and csbs_pkg.
`default_nettype none
`include "cross_stencil_blur_stream_unit_defines.svh"

module csbs_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_tvalid,
   input wire logic                                req_tready,
   input wire logic [47:0]                         req_tdata,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [63:0]                         rsp_tdata,
   input wire logic                                rsp_tlast,
   input wire logic                                csr_psel,
   input wire logic                                csr_penable,
   input wire logic                                csr_pwrite,
   input wire logic [csbs_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input wire logic [csbs_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   input wire logic [csbs_pkg::CSR_DATA_W-1:0]     csr_prdata,
   input wire logic                                csr_pready
);

   logic grid_wr;
   assign grid_wr = csr_psel & csr_penable & csr_pwrite & csr_pready
                    & (csr_paddr[2] == csbs_pkg::REG_GRID_SIDE);

   `CSBS_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "rsp transfer changed while stalled")

   `CSBS_ASSERT_ALWAYS(a_rsp_idle_after_reset, clock, reset |=> !rsp_tvalid, "rsp_tvalid high right after reset")

   `CSBS_ASSERT(a_pair_follows, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid, "second result of a pixel missing")

   `CSBS_ASSERT(a_left_border_zero, clock, reset, rsp_tvalid && (rsp_tdata[13:7] == 7'd0) |-> (rsp_tdata[61:14] == 48'd0), "left border pixel not zero")

   `CSBS_ASSERT(a_csr_readback, clock, reset, grid_wr |=> (csr_paddr[2] != csbs_pkg::REG_GRID_SIDE) || (csr_prdata[7:0] == $past(csr_pwdata[7:0])), "grid_side readback mismatch")

endmodule

bind cross_stencil_blur_stream_unit csbs_checker u_csbs_checker (.*);

`default_nettype wire

// ===== test/cross_stencil_blur_stream_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for cross_stencil_blur_stream_unit: raster RGB pixel stream plus
// grid_side writes over the csr port, every result transfer checked against a local blur model
// or typed directed values. Depends on csbs_pkg and the unit's RTL.
module cross_stencil_blur_stream_unit_tb;
   import csbs_pkg::*;

   localparam int CLK_HALF       = 2;
   localparam int RESET_CYCLES   = 9;
   localparam int SETTLE_CYCLES  = 8;
   localparam int TAIL_CYCLES    = 20;
   localparam int QUIET_LIMIT    = 2000;
   localparam int LONG_HOLD      = 100;
   localparam int HOLD_AT_RESULT = 200;
   localparam int RANDOM_ITEMS   = 900;
   localparam int MAX_PRINTED    = 40;
   localparam logic [39:0] BLUR_MUL   = 40'd13107;
   localparam logic [39:0] BLUR_ROUND = 40'd32768;
   localparam logic [CSR_ADDR_W-1:0] SIDE_ADDR = CSR_ADDR_W'(4 * REG_GRID_SIDE);

   typedef enum logic {STEP_PIXEL, STEP_SIDE} step_kind_e;

   typedef struct {
      step_kind_e  kind;
      logic [31:0] side_value;
      pixel_type   px;
      int          typed_count;   // -1: take the blur model
      result_type  typed0;
      result_type  typed1;
   } stim_step_t;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [47:0]           req_tdata   = '0;  // red, green, blue
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [63:0]           rsp_tdata;         // row, col, red, green, blue
   logic                  rsp_tlast;         // run_end
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // blur model state
   pixel_type   line_rows [2*MAX_SIDE];
   int unsigned next_row = 0;
   int unsigned next_col = 0;
   logic [7:0]  side_reg = SIDE_RESET;

   result_type  blur_expect [$];
   stim_step_t  stim_steps [$];
   int unsigned bad_count    = 0;
   int unsigned quiet_cycles = 0;

   cross_stencil_blur_stream_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(CLK_HALF) clock = ~clock;

   function automatic int unsigned side_eff(input logic [7:0] v);
      if (v < SIDE_MIN) return SIDE_MIN;
      if (v > MAX_SIDE) return MAX_SIDE;
      return v;
   endfunction

   function automatic int unsigned store_slot(input int unsigned r, input int unsigned c);
      return (r % 2) * MAX_SIDE + (c % MAX_SIDE);
   endfunction

   function automatic logic [15:0] fifth_of_sum(input logic [15:0] a, b, c, d, e);
      logic [18:0] s;
      logic [39:0] p;
      s = 19'(a) + 19'(b) + 19'(c) + 19'(d) + 19'(e);
      p = 40'(s) * BLUR_MUL + BLUR_ROUND;
      return p[31:16];
   endfunction

   function automatic result_type blur_result(input int unsigned r, input int unsigned c,
                                              input pixel_type p, input logic last);
      result_type res;
      res.row     = r[OUT_POS_W-1:0];
      res.col     = c[OUT_POS_W-1:0];
      res.red     = p.red;
      res.green   = p.green;
      res.blue    = p.blue;
      res.run_end = last;
      return res;
   endfunction

   // advances the model by one pixel; returns how many results it causes
   function automatic int blur_predict(input pixel_type px,
                                       output result_type res0, output result_type res1);
      int unsigned n, r, c, fr;
      pixel_type   up, mid, lf, rt, avg;
      bit          on_border;
      int          found;
      n = side_eff(side_reg);
      r = next_row;
      c = next_col;
      found = 0;
      res0 = '0;
      res1 = '0;
      if (r >= 1) begin
         fr = r - 1;
         avg = '0;
         on_border = (fr == 0) || (c == 0) || (c >= n - 1);
         if (!on_border) begin
            up  = line_rows[store_slot(fr - 1, c)];
            mid = line_rows[store_slot(fr, c)];
            lf  = line_rows[store_slot(fr, c - 1)];
            rt  = line_rows[store_slot(fr, c + 1)];
            avg.red   = fifth_of_sum(up.red, mid.red, lf.red, rt.red, px.red);
            avg.green = fifth_of_sum(up.green, mid.green, lf.green, rt.green, px.green);
            avg.blue  = fifth_of_sum(up.blue, mid.blue, lf.blue, rt.blue, px.blue);
         end
         res0 = blur_result(fr, c, avg, r != n - 1);
         found = 1;
         if (r == n - 1) begin
            res1 = blur_result(r, c, '0, 1'b1);
            found = 2;
         end
      end
      line_rows[store_slot(r, c)] = px;
      if (c + 1 >= n) begin
         next_col = 0;
         next_row = (r + 1 >= n) ? 0 : r + 1;
      end else begin
         next_col = c + 1;
      end
      return found;
   endfunction

   task automatic push_predicted(input pixel_type px);
      result_type a, b;
      int         found;
      found = blur_predict(px, a, b);
      if (found >= 1) blur_expect.push_back(a);
      if (found == 2) blur_expect.push_back(b);
   endtask

   task automatic log_mismatch(input string msg);
      bad_count++;
      if (bad_count <= MAX_PRINTED) $display("MISMATCH @%0t: %s", $time, msg);
   endtask

   task automatic cmp_field(input string name, input int unsigned got, input int unsigned want,
                            input result_type ref_res);
      if (got != want)
         log_mismatch($sformatf("%s of pixel (%0d,%0d): got %0h, expected %0h",
                                name, ref_res.row, ref_res.col, got, want));
   endtask

   task automatic check_result(input logic [63:0] d, input logic last);
      result_type want;
      if (blur_expect.size() == 0) begin
         log_mismatch($sformatf("unexpected result for pixel (%0d,%0d)", d[6:0], d[13:7]));
         return;
      end
      want = blur_expect.pop_front();
      cmp_field("row", d[6:0], want.row, want);
      cmp_field("col", d[13:7], want.col, want);
      cmp_field("red", d[29:14], want.red, want);
      cmp_field("green", d[45:30], want.green, want);
      cmp_field("blue", d[61:46], want.blue, want);
      cmp_field("pad", d[63:62], 0, want);
      cmp_field("run_end", last, want.run_end, want);
   endtask

   task automatic add_step(input step_kind_e kind, input logic [31:0] sv, input pixel_type px,
                           input int tc, input result_type t0, input result_type t1);
      stim_step_t s;
      s.kind        = kind;
      s.side_value  = sv;
      s.px          = px;
      s.typed_count = tc;
      s.typed0      = t0;
      s.typed1      = t1;
      stim_steps.push_back(s);
   endtask

   task automatic build_directed();
      pixel_type  ones, zeros, nearly;
      result_type nil;
      int         r, c;
      ones   = '1;
      zeros  = '0;
      nearly = '{default: 16'hFFFE};  // five full-scale samples times one fifth
      nil    = '0;
      // default side 65: first row stays silent
      add_step(STEP_PIXEL, 0, ones, 0, nil, nil);
      add_step(STEP_PIXEL, 0, pixel_type'(48'h1234_5678_9ABC), 0, nil, nil);
      add_step(STEP_SIDE, SIDE_MIN, zeros, -1, nil, nil);
      for (r = 0; r < 3; r++)
         for (c = 0; c < 3; c++)
            if (r == 0)
               add_step(STEP_PIXEL, 0, ones, 0, nil, nil);
            else if (r == 1)
               add_step(STEP_PIXEL, 0, ones, 1, blur_result(0, c, zeros, 1'b1), nil);
            else
               add_step(STEP_PIXEL, 0, ones, 2,
                        blur_result(1, c, (c == 1) ? nearly : zeros, 1'b0),
                        blur_result(2, c, zeros, 1'b1));
      // second frame after wrap: checkerboard of full scale and zero
      for (r = 0; r < 3; r++)
         for (c = 0; c < 3; c++)
            add_step(STEP_PIXEL, 0, ((r + c) % 2 == 0) ? ones : zeros, -1, nil, nil);
      // side below minimum, then a write mid-frame with junk in the upper bits
      add_step(STEP_SIDE, 0, zeros, -1, nil, nil);
      add_step(STEP_PIXEL, 0, pixel_type'(48'h5555_AAAA_5555), -1, nil, nil);
      add_step(STEP_PIXEL, 0, pixel_type'(48'hAAAA_5555_AAAA), -1, nil, nil);
      add_step(STEP_PIXEL, 0, pixel_type'(48'h8000_0001_7FFE), -1, nil, nil);
      add_step(STEP_PIXEL, 0, pixel_type'(48'h0001_8000_FFFF), -1, nil, nil);
      add_step(STEP_SIDE, 32'hA5A5_A5FF, zeros, -1, nil, nil);
      add_step(STEP_PIXEL, 0, ones, -1, nil, nil);
      add_step(STEP_PIXEL, 0, zeros, -1, nil, nil);
   endtask

   task automatic wait_drained();
      while (blur_expect.size() != 0) @(posedge clock);
   endtask

   task automatic send_pixel(input pixel_type px, input int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic write_grid_side(input logic [31:0] value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= SIDE_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      side_reg = value[7:0];
      next_row = 0;
      next_col = 0;
      // read back
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== CSR_DATA_W'(value[7:0]))
         log_mismatch($sformatf("grid_side reads %0h, expected %0h", csr_prdata, value[7:0]));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic logic [15:0] random_channel();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic run_random();
      int          phase, total, count, gap_top, i;
      int unsigned n;
      logic [31:0] side_value;
      pixel_type   px;
      phase = 0;
      total = 0;
      while (total < RANDOM_ITEMS) begin
         case (phase)
            1: side_value = $urandom_range(0, 1) ? MAX_SIDE : $urandom_range(MAX_SIDE + 1, 255);
            4: side_value = SIDE_RESET;
            default: side_value = ($urandom_range(0, 5) == 0) ? $urandom_range(0, SIDE_MIN - 1)
                                                              : $urandom_range(SIDE_MIN, 12);
         endcase
         n = side_eff(side_value[7:0]);
         // big grids: only the first rows; small grids: whole frames plus a partial one
         if (n > 12) count = 2 * n + $urandom_range(1, n);
         else count = $urandom_range(1, 3) * n * n + $urandom_range(0, n * n - 1);
         gap_top = ($urandom_range(0, 3) == 0) ? 0 : 5;
         write_grid_side(side_value);
         for (i = 0; i < count; i++) begin
            px.red   = random_channel();
            px.green = random_channel();
            px.blue  = random_channel();
            send_pixel(px, $urandom_range(0, gap_top));
            push_predicted(px);
            if (phase == 2 && i == count / 2) begin
               req_tvalid <= 1'b0;
               @(posedge clock);
               wait_drained();
            end
         end
         total += count;
         phase++;
      end
   endtask

   initial begin : stimulus
      result_type spare0, spare1;
      build_directed();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (stim_steps[k]) begin
         if (stim_steps[k].kind == STEP_SIDE) begin
            write_grid_side(stim_steps[k].side_value);
         end else begin
            send_pixel(stim_steps[k].px, $urandom_range(0, 5));
            if (stim_steps[k].typed_count < 0) begin
               push_predicted(stim_steps[k].px);
            end else begin
               void'(blur_predict(stim_steps[k].px, spare0, spare1));
               if (stim_steps[k].typed_count >= 1) blur_expect.push_back(stim_steps[k].typed0);
               if (stim_steps[k].typed_count == 2) blur_expect.push_back(stim_steps[k].typed1);
            end
         end
      end
      run_random();
      req_tvalid <= 1'b0;
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (bad_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin : result_sink
      int unsigned wait_cycles, stall_top, taken;
      bit          held;
      stall_top = 5;
      taken     = 0;
      held      = 0;
      @(negedge reset);
      forever begin
         if (!held && taken >= HOLD_AT_RESULT && req_tvalid) begin
            wait_cycles = LONG_HOLD;
            held = 1;
         end else begin
            wait_cycles = $urandom_range(0, stall_top);
         end
         if (wait_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         check_result(rsp_tdata, rsp_tlast);
         taken++;
         if (taken % 64 == 0) stall_top = $urandom_range(0, 1) * 5;
      end
   end

   // watchdog: cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles < QUIET_LIMIT) begin
         quiet_cycles <= quiet_cycles + 1;
      end else begin
         $display("== FAIL ==");
         $finish;
      end
   end

endmodule
